/* sv/lct_pkg.sv */
// ----------------------------------------------------------------------------
// lct_pkg: shared types and constants for the link credit table
// Command and result layouts, table entry layout, mode and status codes.
// ----------------------------------------------------------------------------
package lct_pkg;

  localparam int NODE_LIMIT    = 1023;
  localparam int TABLE_ENTRIES = 64;

  localparam int SRC_W = (NODE_LIMIT > 1) ? $clog2(NODE_LIMIT + 1) : 1;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic [2:0] MODE_ADD     = 3'd0;
  localparam logic [2:0] MODE_QUERY   = 3'd1;
  localparam logic [2:0] MODE_SET     = 3'd2;
  localparam logic [2:0] MODE_CONSUME = 3'd3;
  localparam logic [2:0] MODE_CONN    = 3'd4;
  localparam logic [2:0] MODE_REMOVE  = 3'd5;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NO_LINK = 2'd1;
  localparam logic [1:0] ST_EXPIRED = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] source_node;
    logic [15:0] target_node;
    logic [15:0] amount;
    logic [47:0] expiry_time;
    logic [47:0] now_time;
  } cmd_t;

  typedef struct packed {
    logic [15:0] credit_out;
    logic        success;
    logic [1:0]  status;
  } res_t;

  typedef struct packed {
    logic             valid;
    logic [SRC_W-1:0] source;
    logic [15:0]      target;
    logic [15:0]      credit;
    logic [47:0]      expiry;
  } entry_t;

  // direct write into one cell, used to place a new link
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    entry_t           data;
  } cell_wr_t;

endpackage

/* sv/lct_cell.sv */
// ----------------------------------------------------------------------------
// lct_cell: one table entry in the rotating chain
// Takes its neighbor's entry when the chain shifts, or a direct write.
// ----------------------------------------------------------------------------
module lct_cell
  import lct_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   shift_i,
  input  entry_t shin_i,
  input  logic   wr_i,
  input  entry_t wr_data_i,
  output entry_t q_o
);

  logic   valid_q;
  entry_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= shin_i.valid;
    end else if (wr_i) begin
      valid_q <= wr_data_i.valid;
    end
  end

  // payload carries no reset; only valid entries are ever used
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= shin_i;
    end else if (wr_i) begin
      data_q <= wr_data_i;
    end
  end

  always_comb begin
    q_o       = data_q;
    q_o.valid = valid_q;
  end

endmodule

/* sv/lct_ctrl.sv */
// ----------------------------------------------------------------------------
// lct_ctrl: command sequencer for the link credit table
// Scans the rotating entry chain at its head, edits the matching entry in
// flight, tracks the lowest free slot and places new links after the scan.
// ----------------------------------------------------------------------------
module lct_ctrl
  import lct_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  cmd_t     cmd_i,
  output logic     busy,
  input  entry_t   head_i,
  output entry_t   head_ret_o,
  output logic     shift_o,
  output cell_wr_t wr_o,
  output logic     done_o,
  output res_t     res_o
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMMIT} state_e;

  state_e           state_q;
  cmd_t             cmd_q;
  logic [SRC_W-1:0] src_q;
  logic [IDX_W-1:0] idx_q;
  logic             found_q;
  res_t             hit_q;
  logic             free_found_q;
  logic [IDX_W-1:0] free_idx_q;
  logic             place_q;
  logic             done_q;
  res_t             res_q;

  logic [SRC_W-1:0] src_clamp;
  logic             match;
  logic             expired;
  logic [15:0]      diff;
  res_t             hit;
  entry_t           ret;
  logic             last;
  logic             free_now;
  logic             found_d;
  logic             free_found_d;
  res_t             final_res;
  logic             place_d;

  assign src_clamp = (cmd_i.source_node > 16'(NODE_LIMIT)) ? SRC_W'(NODE_LIMIT)
                                                           : cmd_i.source_node[SRC_W-1:0];

  // head processing: the entry leaving the head goes back into the tail
  always_comb begin
    match   = head_i.valid && (head_i.source == src_q) &&
              (head_i.target == cmd_q.target_node);
    expired = head_i.expiry <= cmd_q.now_time;
    diff    = head_i.credit - cmd_q.amount;
    ret     = head_i;
    hit     = '0;
    if (match) begin
      case (cmd_q.mode)
        MODE_ADD: begin
          ret.credit = cmd_q.amount;
          ret.expiry = cmd_q.expiry_time;
        end
        MODE_QUERY, MODE_SET, MODE_CONSUME: begin
          if (expired) begin
            ret.valid  = 1'b0;
            hit.status = ST_EXPIRED;
          end else if (cmd_q.mode == MODE_QUERY) begin
            hit.credit_out = head_i.credit;
          end else if (cmd_q.mode == MODE_SET) begin
            ret.credit = cmd_q.amount;
          end else if (head_i.credit >= cmd_q.amount) begin
            ret.credit  = diff;
            hit.success = 1'b1;
            if (diff == 16'd0) begin
              ret.valid = 1'b0;
            end
          end
        end
        MODE_CONN: begin
          hit.success = (head_i.credit != 16'd0) && !expired;
        end
        MODE_REMOVE: begin
          ret.valid = 1'b0;
        end
        default: begin
          ret = head_i;
        end
      endcase
    end
  end

  assign head_ret_o = ret;
  assign shift_o    = (state_q == S_SCAN);
  assign last       = (idx_q == IDX_W'(TABLE_ENTRIES - 1));
  assign free_now   = !head_i.valid && !free_found_q;
  assign found_d    = found_q || match;
  assign free_found_d = free_found_q || !head_i.valid;

  // result once the whole table has gone by the head
  always_comb begin
    final_res = '0;
    place_d   = 1'b0;
    if (found_d) begin
      final_res = match ? hit : hit_q;
    end else begin
      case (cmd_q.mode)
        MODE_ADD: begin
          if (free_found_d) begin
            place_d = 1'b1;
          end else begin
            final_res.status = ST_FULL;
          end
        end
        MODE_QUERY, MODE_SET, MODE_CONSUME, MODE_CONN, MODE_REMOVE: begin
          final_res.status = ST_NO_LINK;
        end
        default: begin
          final_res = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      place_q      <= 1'b0;
      done_q       <= 1'b0;
      cmd_q        <= '0;
      src_q        <= '0;
      hit_q        <= '0;
      free_idx_q   <= '0;
      res_q        <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            cmd_q        <= cmd_i;
            src_q        <= src_clamp;
            idx_q        <= '0;
            found_q      <= 1'b0;
            free_found_q <= 1'b0;
            state_q      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (match) begin
            found_q <= 1'b1;
            hit_q   <= hit;
          end
          if (free_now) begin
            free_found_q <= 1'b1;
            free_idx_q   <= idx_q;
          end
          if (last) begin
            res_q   <= final_res;
            place_q <= place_d;
            done_q  <= 1'b1;
            state_q <= S_COMMIT;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_COMMIT: begin
          place_q <= 1'b0;
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // chain is back in index order here, so the free slot is addressed directly
  always_comb begin
    wr_o             = '0;
    wr_o.en          = (state_q == S_COMMIT) && place_q;
    wr_o.idx         = free_idx_q;
    wr_o.data.valid  = 1'b1;
    wr_o.data.source = src_q;
    wr_o.data.target = cmd_q.target_node;
    wr_o.data.credit = cmd_q.amount;
    wr_o.data.expiry = cmd_q.expiry_time;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* sv/link_credit_table_with_expiry.sv */
// ----------------------------------------------------------------------------
// link_credit_table_with_expiry: directed link credit table
// Ring of entry cells rotated past a single head processor.
// ----------------------------------------------------------------------------
// One command is taken when start is high and busy is low. The command is
// captured first, then the ring of cells rotates every entry past the head,
// and last a new link is placed if one is needed. done_o pulses for exactly
// one cycle with the
// result at the end of the rotation, and the result must be taken then, as
// there is no way to stall it. Entry payload has no reset; the valid bits
// clear at reset, so the table is usable right away.
module link_credit_table_with_expiry
  import lct_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  cmd_t cmd_i,
  output logic busy,
  output logic done_o,
  output res_t res_o
);

  entry_t   cell_q [TABLE_ENTRIES];
  entry_t   head_ret;
  logic     shift;
  cell_wr_t wr;

  lct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .cmd_i      (cmd_i),
    .busy       (busy),
    .head_i     (cell_q[0]),
    .head_ret_o (head_ret),
    .shift_o    (shift),
    .wr_o       (wr),
    .done_o     (done_o),
    .res_o      (res_o)
  );

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    entry_t shin;
    if (i == TABLE_ENTRIES - 1) begin : g_tail
      assign shin = head_ret;
    end else begin : g_mid
      assign shin = cell_q[i+1];
    end

    lct_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .shift_i   (shift),
      .shin_i    (shin),
      .wr_i      (wr.en && (wr.idx == IDX_W'(i))),
      .wr_data_i (wr.data),
      .q_o       (cell_q[i])
    );
  end

endmodule

/* sv/lct_chk.sv */
// ----------------------------------------------------------------------------
// lct_chk: port-level checks for the link credit table
// Command acceptance, result strobe timing and result field consistency.
// ----------------------------------------------------------------------------
module lct_chk
  import lct_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input res_t res_o
);

  // an accepted transaction keeps the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transaction");

  // a result only shows up while a transaction is in flight
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe while idle");

  // the result strobe is a single-cycle strobe
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // credit is only reported by a successful lookup, never with success
  a_credit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (res_o.credit_out != 16'd0)) |->
      (res_o.status == ST_DONE) && !res_o.success)
    else $error("credit reported with bad status or success");

  a_success_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.success) |-> (res_o.status == ST_DONE))
    else $error("success with non-done status");

endmodule

bind link_credit_table_with_expiry lct_chk u_lct_chk (.*);
